// ===== src/dngd_pkg.sv =====
// ----------------------------------------------------------------------------
// dngd_pkg
// Shared widths, calendar constants and month tables for the day number to
// Gregorian date converter.
// ----------------------------------------------------------------------------
package dngd_pkg;

    localparam int DAY_W   = 23;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;

    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_YEAR = 365;
    localparam int DAYS_LEAP = 366;
    localparam int DAY_LIMIT = 3652425;

    // floor(2^32 / 146097) and floor(2^24 / 1461): quotient low by at most one
    localparam int RECIP_400Y = 29398;
    localparam int RECIP_4Y   = 11483;

    localparam int YEAR_MAX    = 9999;
    localparam int DOY_SAT     = 364;
    localparam int MONTHS      = 12;

    typedef logic [DOY_W-1:0] cum_tab_t [13];

    localparam cum_tab_t CUM_COMMON = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam cum_tab_t CUM_LEAP = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] val;
        val = leap ? CUM_LEAP[idx] : CUM_COMMON[idx];
        return val;
    endfunction

endpackage

// ===== src/dngd_in_if.sv =====
// ----------------------------------------------------------------------------
// dngd_in_if
// Input channel: signed day count with valid/ready transfer.
// ----------------------------------------------------------------------------
interface dngd_in_if import dngd_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [DAY_W-1:0] day_number;

    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

// ===== src/dngd_out_if.sv =====
// ----------------------------------------------------------------------------
// dngd_out_if
// Output channel: calendar date with valid/ready transfer.
// ----------------------------------------------------------------------------
interface dngd_out_if import dngd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year;
    logic [DOY_W-1:0]   day_of_year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;

    modport source (output valid, output year, output day_of_year, output month,
                    output day_of_month, input ready);
    modport sink   (input valid, input year, input day_of_year, input month,
                    input day_of_month, output ready);
endinterface

// ===== src/day_number_to_gregorian_date_core.sv =====
// ----------------------------------------------------------------------------
// day_number_to_gregorian_date_core
// Converts a signed day count since 0000-01-01 into year, day of year, month
// and day of month (proleptic Gregorian, year 0 leap), clamped to
// 0000-01-01 .. 9999-12-31.
//
//   channel   dir  transfer when          payload
//   day_in    in   valid && ready         day_number
//   date_out  out  valid && ready         year, day_of_year, month, day_of_month
//
// One transfer per cycle sustained while date_out is ready, through an 11-stage
// pipeline (two reciprocal multiplies with correction for the 400-year and
// 4-year splits, compare ladders for the 100-year and year splits).
// Each stage holds its item until the next stage frees, so bubbles collapse
// and a stalled output backs up one stage at a time.
// rst_n clears all stage valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
module day_number_to_gregorian_date_core import dngd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dngd_in_if.sink     day_in,
    dngd_out_if.source  date_out
);

    localparam int NSTAGE = 11;

    typedef struct packed {
        logic               lo;
        logic               hi;
        logic [21:0]        d;
        logic [4:0]         q400;
        logic [18:0]        r400;
        logic               done400;
        logic               done100;
        logic [1:0]         q100;
        logic [15:0]        e100;
        logic [15:0]        f;
        logic [4:0]         q4;
        logic [11:0]        r4;
        logic [1:0]         y;
        logic [DOY_W-1:0]   doy;
        logic               leap;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   dom;
    } pipe_t;

    pipe_t               stage_reg  [NSTAGE];
    pipe_t               stage_next [NSTAGE];
    logic [NSTAGE-1:0]   valid_reg;
    logic [NSTAGE-1:0]   valid_next;
    logic [NSTAGE:0]     adv;

    // stage advance: a stage takes new data when empty or when it drains
    always_comb
    begin
        adv[NSTAGE] = date_out.ready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NSTAGE; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = (k == 0) ? day_in.valid : valid_reg[(k == 0) ? 0 : k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    assign day_in.ready = adv[0];

    always_comb
    begin
        logic [36:0]      prod37;
        logic [21:0]      diff22;
        logic [17:0]      e18;
        logic [17:0]      diff18;
        logic [29:0]      prod30;
        logic [15:0]      diff16;
        logic [10:0]      g11;
        logic [10:0]      diff11;
        logic [YEAR_W-1:0] yr;
        logic [MONTH_W-1:0] m;
        logic [DOY_W-1:0] diff9;
        pipe_t            nx;

        // stage 0: clamp flags, 400-year quotient estimate
        nx        = '0;
        nx.lo     = day_in.day_number[DAY_W-1] || (day_in.day_number == '0);
        nx.hi     = !day_in.day_number[DAY_W-1] &&
                    (day_in.day_number[21:0] >= 22'(DAY_LIMIT));
        nx.d      = day_in.day_number[21:0];
        prod37    = 37'(day_in.day_number[21:0]) * 37'(RECIP_400Y);
        nx.q400   = prod37[36:32];
        stage_next[0] = nx;

        // stage 1: 400-year remainder
        nx        = stage_reg[0];
        diff22    = nx.d - 22'(nx.q400) * 22'(DAYS_400Y);
        nx.r400   = diff22[18:0];
        stage_next[1] = nx;

        // stage 2: quotient correction
        nx = stage_reg[1];
        if (nx.r400 >= 19'(DAYS_400Y))
        begin
            nx.r400 = nx.r400 - 19'(DAYS_400Y);
            nx.q400 = nx.q400 + 5'd1;
        end
        stage_next[2] = nx;

        // stage 3: 100-year split
        nx         = stage_reg[2];
        nx.done400 = nx.r400 < 19'(DAYS_LEAP);
        e18        = nx.r400[17:0] - 18'd1;
        if (e18 >= 18'(3 * DAYS_100Y))
        begin
            nx.q100 = 2'd3;
        end
        else if (e18 >= 18'(2 * DAYS_100Y))
        begin
            nx.q100 = 2'd2;
        end
        else if (e18 >= 18'(DAYS_100Y))
        begin
            nx.q100 = 2'd1;
        end
        else
        begin
            nx.q100 = 2'd0;
        end
        diff18  = e18 - 18'(nx.q100) * 18'(DAYS_100Y);
        nx.e100 = diff18[15:0];
        stage_next[3] = nx;

        // stage 4: 4-year quotient estimate
        nx         = stage_reg[3];
        nx.done100 = !nx.done400 && (nx.e100 < 16'(DAYS_YEAR));
        nx.f       = nx.e100 + 16'd1;
        prod30     = 30'(nx.f) * 30'(RECIP_4Y);
        nx.q4      = prod30[28:24];
        nx.doy     = nx.done400 ? nx.r400[DOY_W-1:0] : nx.e100[DOY_W-1:0];
        stage_next[4] = nx;

        // stage 5: 4-year remainder
        nx     = stage_reg[4];
        diff16 = nx.f - 16'(nx.q4) * 16'(DAYS_4Y);
        nx.r4  = diff16[11:0];
        stage_next[5] = nx;

        // stage 6: quotient correction
        nx = stage_reg[5];
        if (nx.r4 >= 12'(DAYS_4Y))
        begin
            nx.r4 = nx.r4 - 12'(DAYS_4Y);
            nx.q4 = nx.q4 + 5'd1;
        end
        stage_next[6] = nx;

        // stage 7: single years, leap flag
        nx     = stage_reg[6];
        g11    = nx.r4[10:0] - 11'd1;
        diff11 = '0;
        if (nx.done400 || nx.done100)
        begin
            nx.y    = 2'd0;
            nx.leap = nx.done400;
        end
        else if (nx.r4 >= 12'(DAYS_LEAP))
        begin
            if (g11 >= 11'(3 * DAYS_YEAR))
            begin
                nx.y = 2'd3;
            end
            else if (g11 >= 11'(2 * DAYS_YEAR))
            begin
                nx.y = 2'd2;
            end
            else
            begin
                nx.y = 2'd1;
            end
            diff11  = g11 - 11'(nx.y) * 11'(DAYS_YEAR);
            nx.doy  = diff11[DOY_W-1:0];
            nx.leap = 1'b0;
        end
        else
        begin
            nx.y    = 2'd0;
            nx.doy  = nx.r4[DOY_W-1:0];
            nx.leap = 1'b1;
        end
        stage_next[7] = nx;

        // stage 8: year assembly and clamping
        nx = stage_reg[7];
        yr = 14'(nx.q400) * 14'd400;
        if (!nx.done400)
        begin
            yr = yr + 14'(nx.q100) * 14'd100;
        end
        if (!nx.done400 && !nx.done100)
        begin
            yr = yr + 14'(nx.q4) * 14'd4 + 14'(nx.y);
        end
        if (nx.lo)
        begin
            nx.year = '0;
            nx.doy  = '0;
            nx.leap = 1'b1;
        end
        else if (nx.hi)
        begin
            nx.year = YEAR_W'(YEAR_MAX);
            nx.doy  = DOY_W'(DOY_SAT);
            nx.leap = 1'b0;
        end
        else
        begin
            nx.year = yr;
        end
        stage_next[8] = nx;

        // stage 9: month lookup
        nx = stage_reg[8];
        m  = MONTH_W'(MONTHS);
        for (int i = MONTHS; i >= 1; i--)
        begin
            if (nx.doy < cum_days(nx.leap, MONTH_W'(i)))
            begin
                m = MONTH_W'(i);
            end
        end
        nx.month = m;
        stage_next[9] = nx;

        // stage 10: day of month
        nx     = stage_reg[9];
        diff9  = nx.doy - cum_days(nx.leap, nx.month - MONTH_W'(1)) + 9'd1;
        nx.dom = diff9[DOM_W-1:0];
        stage_next[10] = nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTAGE; k++)
        begin
            if (adv[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign date_out.valid        = valid_reg[NSTAGE-1];
    assign date_out.year         = stage_reg[NSTAGE-1].year;
    assign date_out.day_of_year  = stage_reg[NSTAGE-1].doy;
    assign date_out.month        = stage_reg[NSTAGE-1].month;
    assign date_out.day_of_month = stage_reg[NSTAGE-1].dom;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed day counts into the day number to Gregorian date converter
// and checks every returned date against a behavioral calendar model. A
// directed set hits clamping, leap days, century and 400-year boundaries;
// random counts follow, partly clustered near year boundaries. Both channels idle
// at random, and every 400th random count is held until the pipeline has drained.
// ----------------------------------------------------------------------------
module testbench;
    import dngd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 8;
    localparam int N_RANDOM    = 1275;
    localparam int DRAIN_CYC   = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    localparam int CUM_DAYS [2][13] = '{
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
    };

    localparam int DIRECTED [25] = '{
        0, -1, -4194304, 4194303, 1, 30, 31, 59, 60, 365, 366, 1460, 1461,
        1520, 36524, 36525, 36889, 36890, 146096, 146097, 146462, 694020,
        730544, 3652424, 3652425
    };

    // start offsets of centuries in a 400-year cycle and of years in a leap cycle
    localparam int CENTURY_OFS [4] = '{0, 36525, 73049, 109573};
    localparam int YEAR_OFS    [5] = '{0, 366, 731, 1096, 1461};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [DOY_W-1:0]   day_of_year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
    } date_t;

    typedef struct {
        logic signed [DAY_W-1:0] day;
        bit                      hold;
    } day_item_t;

    logic clk;
    logic rst_n;

    dngd_in_if  day_in ();
    dngd_out_if date_out ();

    day_number_to_gregorian_date_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .day_in   (day_in),
        .date_out (date_out)
    );

    day_item_t pending_days[$];
    date_t     expected_dates[$];

    int accepted;
    int total_days;
    int checked;
    int mismatches;
    int unexpected;
    int cycles;
    int clamped_low;
    int clamped_high;
    int leap_days;
    int year_ends;

    function automatic date_t to_date(input logic signed [DAY_W-1:0] dn);
        int    d;
        int    yr;
        int    m;
        int    lp;
        date_t r;
        if (dn <= 0)
        begin
            yr = 0;
            d  = 0;
        end
        else if (dn >= DAY_LIMIT)
        begin
            yr = YEAR_MAX;
            d  = DOY_SAT;
        end
        else
        begin
            d  = dn;
            yr = (d / DAYS_400Y) * 400;
            d  = d % DAYS_400Y;
            if (d >= DAYS_LEAP)
            begin
                d  = d - 1;
                yr = yr + (d / DAYS_100Y) * 100;
                d  = d % DAYS_100Y;
                if (d >= DAYS_YEAR)
                begin
                    d  = d + 1;
                    yr = yr + (d / DAYS_4Y) * 4;
                    d  = d % DAYS_4Y;
                    if (d >= DAYS_LEAP)
                    begin
                        d  = d - 1;
                        yr = yr + d / DAYS_YEAR;
                        d  = d % DAYS_YEAR;
                    end
                end
            end
        end
        lp = ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 1 : 0;
        m  = MONTHS;
        for (int i = MONTHS; i >= 1; i--)
        begin
            if (d < CUM_DAYS[lp][i])
                m = i;
        end
        r.year         = YEAR_W'(yr);
        r.day_of_year  = DOY_W'(d);
        r.month        = MONTH_W'(m);
        r.day_of_month = DOM_W'(d - CUM_DAYS[lp][m-1] + 1);
        return r;
    endfunction

    function automatic logic signed [DAY_W-1:0] pick_day();
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 60)
            d = $urandom_range(1, DAY_LIMIT - 1);
        else if (r < 80)
            d = $urandom_range(0, 24) * DAYS_400Y + CENTURY_OFS[$urandom_range(0, 3)]
                + $urandom_range(0, 24) * DAYS_4Y + YEAR_OFS[$urandom_range(0, 4)]
                + $urandom_range(0, 4) - 2;
        else if (r < 88)
            return {1'b1, (DAY_W-1)'($urandom)};
        else if (r < 94)
            d = $urandom_range(DAY_LIMIT, (1 << (DAY_W - 1)) - 1);
        else
            return DAY_W'($urandom);
        return DAY_W'(d);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        day_item_t it;
        rst_n               = 1'b0;
        day_in.valid        = 1'b0;
        day_in.day_number   = '0;
        date_out.ready      = 1'b0;
        foreach (DIRECTED[i])
        begin
            it.day  = DAY_W'(DIRECTED[i]);
            it.hold = 1'b0;
            pending_days.push_back(it);
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            it.day  = pick_day();
            it.hold = (i % 400 == 0);
            pending_days.push_back(it);
        end
        total_days = pending_days.size();
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        wait (accepted == total_days);
        wait (expected_dates.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        $display("%0d day counts converted and %0d dates checked", accepted, checked);
        $display("clamped low %0d, clamped high %0d, Feb 29 %0d, Dec 31 %0d",
                 clamped_low, clamped_high, leap_days, year_ends);
        if (mismatches == 0 && unexpected == 0 && expected_dates.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d unexpected dates", mismatches, unexpected);
            $display("CHECK FAILED");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d of %0d accepted, %0d dates outstanding",
                     accepted, total_days, expected_dates.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver
    int  gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        date_t     exp_date;
        day_item_t it;
        logic      next_valid;
        if (!rst_n)
        begin
            day_in.valid <= 1'b0;
            gap_left     = 0;
        end
        else
        begin
            next_valid = day_in.valid;
            if (day_in.valid && day_in.ready)
            begin
                exp_date = to_date(day_in.day_number);
                expected_dates.push_back(exp_date);
                accepted = accepted + 1;
                if (day_in.day_number <= 0)
                    clamped_low++;
                if (day_in.day_number >= DAY_LIMIT)
                    clamped_high++;
                if (exp_date.month == 2 && exp_date.day_of_month == 29)
                    leap_days++;
                if (exp_date.month == 12 && exp_date.day_of_month == 31)
                    year_ends++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_days.size() != 0
                         && !(pending_days[0].hold && expected_dates.size() != 0))
                begin
                    it = pending_days.pop_front();
                    day_in.day_number <= it.day;
                    next_valid = 1'b1;
                    gap_left = ((accepted / 150) % 4 == 3) ? 0 : pick_gap();
                end
            end
            day_in.valid <= next_valid;
        end
    end

    // monitor
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        date_t got;
        date_t exp_date;
        if (!rst_n)
        begin
            date_out.ready <= 1'b0;
            stall_left     = 0;
        end
        else
        begin
            if (date_out.valid && date_out.ready)
            begin
                got.year         = date_out.year;
                got.day_of_year  = date_out.day_of_year;
                got.month        = date_out.month;
                got.day_of_month = date_out.day_of_month;
                if (expected_dates.size() == 0)
                begin
                    unexpected++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display("unexpected date %0d/%0d/%0d doy %0d", got.year,
                                 got.month, got.day_of_month, got.day_of_year);
                end
                else
                begin
                    exp_date = expected_dates.pop_front();
                    checked++;
                    if (got.year !== exp_date.year
                        || got.day_of_year !== exp_date.day_of_year
                        || got.month !== exp_date.month
                        || got.day_of_month !== exp_date.day_of_month)
                    begin
                        mismatches++;
                        if (mismatches + unexpected <= MAX_REPORTS)
                            $display("mismatch at date %0d: exp %0d/%0d/%0d doy %0d, got %0d/%0d/%0d doy %0d",
                                     checked, exp_date.year, exp_date.month,
                                     exp_date.day_of_month, exp_date.day_of_year,
                                     got.year, got.month, got.day_of_month,
                                     got.day_of_year);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                date_out.ready <= 1'b0;
            end
            else
            begin
                date_out.ready <= 1'b1;
                if ((cycles / 1000) % 4 != 2 && $urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

endmodule

// ===== sim.f =====
src/dngd_pkg.sv
src/dngd_in_if.sv
src/dngd_out_if.sv
src/day_number_to_gregorian_date_core.sv
tb/testbench.sv
